// ----- sv/pal_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ERASE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FIND   = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_INVALID   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

endpackage

`default_nettype wire

// ----- sv/pal_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pal_store #(
  parameter int DEPTH = pal_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [pal_pkg::DATA_W-1:0] wdata_i,
  input  wire logic [AW-1:0]              raddr_i,
  output logic      [pal_pkg::DATA_W-1:0] rdata_o
);

  logic [pal_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- sv/positional_array_list_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of signed words in a one-port-read, one-port-write store.
// Append, remove and rejected requests finish in the idle state; insert reads then writes
// each moved entry before writing the new one; erase reads then writes each moved entry;
// find reads then checks each compared entry. The longest request is a find over a full list.
// One request at a time; the next is taken once the result is in the output register.
// Reset empties the list (count zero); store contents are not cleared.

module positional_array_list_top #(
  parameter int DEPTH = pal_pkg::DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [pal_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [pal_pkg::POS_W-1:0]    position_i,
  input  wire logic signed [pal_pkg::DATA_W-1:0] item_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [pal_pkg::STATUS_W-1:0]      status_o,
  output logic [pal_pkg::FOUND_W-1:0]       found_index_o,
  output logic [pal_pkg::COUNT_W-1:0]       entry_count_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_RD   = 4'd1;
  localparam logic [3:0] S_INS_WR   = 4'd2;
  localparam logic [3:0] S_INS_LAST = 4'd3;
  localparam logic [3:0] S_ERA_RD   = 4'd4;
  localparam logic [3:0] S_ERA_WR   = 4'd5;
  localparam logic [3:0] S_FND_RD   = 4'd6;
  localparam logic [3:0] S_FND_CHK  = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [pal_pkg::DATA_W-1:0] val_q, val_d;
  logic [pal_pkg::STATUS_W-1:0] pend_stat_q, pend_stat_d;
  logic [CW-1:0] pend_idx_q, pend_idx_d;

  logic out_valid_q, out_valid_d;
  logic [pal_pkg::STATUS_W-1:0] out_stat_q, out_stat_d;
  logic [pal_pkg::FOUND_W-1:0]  out_found_q, out_found_d;
  logic [pal_pkg::COUNT_W-1:0]  out_cnt_q, out_cnt_d;

  logic                       mem_we;
  logic [AW-1:0]              mem_wa, mem_ra;
  logic [pal_pkg::DATA_W-1:0] mem_wd, mem_rd;

  logic [CMPW-1:0] pos_ext, cnt_ext, pidx_ext, pcnt_ext;
  logic [CW-1:0]   idx_m1, idx_p1;
  logic            accept, full, out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign pos_ext    = CMPW'(position_i);
  assign cnt_ext    = CMPW'(cnt_q);
  assign full       = (cnt_q == CW'(DEPTH));
  assign idx_m1     = idx_q - 1'b1;
  assign idx_p1     = idx_q + 1'b1;
  assign out_free   = !out_valid_q || out_ready_i;
  assign pidx_ext   = CMPW'(pend_idx_q);
  assign pcnt_ext   = CMPW'(cnt_q);

  pal_store #(.DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (mem_ra),
    .rdata_o (mem_rd)
  );

  assign mem_ra = (state_q == S_INS_RD) ? idx_m1[AW-1:0] : idx_q[AW-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    val_d       = val_q;
    pend_stat_d = pend_stat_q;
    pend_idx_d  = pend_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_stat_d  = out_stat_q;
    out_found_d = out_found_q;
    out_cnt_d   = out_cnt_q;
    mem_we      = 1'b0;
    mem_wa      = idx_q[AW-1:0];
    mem_wd      = mem_rd;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pend_stat_d = pal_pkg::STAT_OK;
          pend_idx_d  = '0;
          val_d       = item_value_i;
          state_d     = S_DONE;
          case (req_type_i)
            pal_pkg::REQ_APPEND: begin
              if (full) begin
                pend_stat_d = pal_pkg::STAT_FULL;
              end else begin
                mem_we = 1'b1;
                mem_wa = cnt_q[AW-1:0];
                mem_wd = item_value_i;
                cnt_d  = cnt_q + 1'b1;
              end
            end
            pal_pkg::REQ_REMOVE: begin
              if (cnt_q == '0) begin
                pend_stat_d = pal_pkg::STAT_INVALID;
              end else begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            pal_pkg::REQ_INSERT: begin
              if (pos_ext > cnt_ext) begin
                pend_stat_d = pal_pkg::STAT_INVALID;
              end else if (full) begin
                pend_stat_d = pal_pkg::STAT_FULL;
              end else begin
                pos_d   = CW'(pos_ext);
                idx_d   = cnt_q;
                state_d = (pos_ext == cnt_ext) ? S_INS_LAST : S_INS_RD;
              end
            end
            pal_pkg::REQ_ERASE: begin
              if (pos_ext >= cnt_ext) begin
                pend_stat_d = pal_pkg::STAT_INVALID;
              end else if (pos_ext + 1'b1 == cnt_ext) begin
                cnt_d = cnt_q - 1'b1;
              end else begin
                idx_d   = CW'(pos_ext) + 1'b1;
                state_d = S_ERA_RD;
              end
            end
            pal_pkg::REQ_FIND: begin
              if (cnt_q == '0) begin
                pend_stat_d = pal_pkg::STAT_NOT_FOUND;
              end else begin
                idx_d   = '0;
                state_d = S_FND_RD;
              end
            end
            default: begin
              pend_stat_d = pal_pkg::STAT_INVALID;
            end
          endcase
        end
      end
      S_INS_RD: begin
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        // move entry idx-1 up to idx
        mem_we  = 1'b1;
        mem_wa  = idx_q[AW-1:0];
        mem_wd  = mem_rd;
        idx_d   = idx_m1;
        state_d = (idx_m1 == pos_q) ? S_INS_LAST : S_INS_RD;
      end
      S_INS_LAST: begin
        mem_we  = 1'b1;
        mem_wa  = pos_q[AW-1:0];
        mem_wd  = val_q;
        cnt_d   = cnt_q + 1'b1;
        state_d = S_DONE;
      end
      S_ERA_RD: begin
        state_d = S_ERA_WR;
      end
      S_ERA_WR: begin
        // move entry idx down to idx-1
        mem_we = 1'b1;
        mem_wa = idx_m1[AW-1:0];
        mem_wd = mem_rd;
        if (idx_p1 == cnt_q) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_DONE;
        end else begin
          idx_d   = idx_p1;
          state_d = S_ERA_RD;
        end
      end
      S_FND_RD: begin
        state_d = S_FND_CHK;
      end
      S_FND_CHK: begin
        if (mem_rd == val_q) begin
          pend_idx_d = idx_q;
          state_d    = S_DONE;
        end else if (idx_p1 == cnt_q) begin
          pend_stat_d = pal_pkg::STAT_NOT_FOUND;
          state_d     = S_DONE;
        end else begin
          idx_d   = idx_p1;
          state_d = S_FND_RD;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = pend_stat_q;
          out_found_d = pidx_ext[pal_pkg::FOUND_W-1:0];
          out_cnt_d   = pcnt_ext[pal_pkg::COUNT_W-1:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pos_q       <= pos_d;
    val_q       <= val_d;
    pend_stat_q <= pend_stat_d;
    pend_idx_q  <= pend_idx_d;
    out_stat_q  <= out_stat_d;
    out_found_q <= out_found_d;
    out_cnt_q   <= out_cnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_stat_q;
  assign found_index_o = out_found_q;
  assign entry_count_o = out_cnt_q;

endmodule

`default_nettype wire

// ----- bench/positional_array_list_top_tb.sv -----
`timescale 1ns / 1ps

module positional_array_list_top_tb;

  localparam int LIST_DEPTH   = pal_pkg::DEPTH_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 10;
  localparam int POOL_SIZE    = 12;
  localparam logic [pal_pkg::REQ_W-1:0] REQ_UNUSED = 3'd6;

  typedef struct {
    logic [pal_pkg::REQ_W-1:0]         kind;
    logic [pal_pkg::POS_W-1:0]         pos;
    logic signed [pal_pkg::DATA_W-1:0] value;
  } list_req_t;

  typedef struct {
    logic [pal_pkg::STATUS_W-1:0] status;
    logic [pal_pkg::FOUND_W-1:0]  found_index;
    logic [pal_pkg::COUNT_W-1:0]  entry_count;
  } list_resp_t;

  logic                              clk_i;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic [pal_pkg::REQ_W-1:0]         req_type_i = '0;
  logic [pal_pkg::POS_W-1:0]         position_i = '0;
  logic signed [pal_pkg::DATA_W-1:0] item_value_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [pal_pkg::STATUS_W-1:0]      status_o;
  logic [pal_pkg::FOUND_W-1:0]       found_index_o;
  logic [pal_pkg::COUNT_W-1:0]       entry_count_o;

  positional_array_list_top #(
    .DEPTH(LIST_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .found_index_o(found_index_o),
    .entry_count_o(entry_count_o)
  );

  list_req_t                         pending_reqs[$];
  list_resp_t                        expected_resps[$];
  logic signed [pal_pkg::DATA_W-1:0] list_words [LIST_DEPTH];
  int unsigned                       list_count = 0;
  int unsigned                       planned_count = 0;
  logic signed [pal_pkg::DATA_W-1:0] value_pool [POOL_SIZE];
  bit                                growing = 1'b1;
  int                                send_idle_pct = 0;
  int                                recv_stall_pct = 0;
  bit                                req_taken = 1'b0;
  bit                                hold_rx = 1'b0;
  int                                hold_requests = 0;
  int                                fail_count = 0;
  int                                cycle_count = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Apply one accepted request to the list copy and record its expected result.
  function automatic void apply_list_request(list_req_t req);
    list_resp_t resp;
    int unsigned i;
    int unsigned pos;
    bit hit;
    resp.status      = pal_pkg::STAT_OK;
    resp.found_index = '0;
    pos = req.pos;
    hit = 1'b0;
    case (req.kind)
      pal_pkg::REQ_APPEND: begin
        if (list_count >= LIST_DEPTH) begin
          resp.status = pal_pkg::STAT_FULL;
        end else begin
          list_words[list_count] = req.value;
          list_count++;
        end
      end
      pal_pkg::REQ_REMOVE: begin
        if (list_count == 0) resp.status = pal_pkg::STAT_INVALID;
        else list_count--;
      end
      pal_pkg::REQ_INSERT: begin
        if (pos > list_count) begin
          resp.status = pal_pkg::STAT_INVALID;
        end else if (list_count >= LIST_DEPTH) begin
          resp.status = pal_pkg::STAT_FULL;
        end else begin
          for (i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = req.value;
          list_count++;
        end
      end
      pal_pkg::REQ_ERASE: begin
        if (pos >= list_count) begin
          resp.status = pal_pkg::STAT_INVALID;
        end else begin
          for (i = pos + 1; i < list_count; i++) list_words[i-1] = list_words[i];
          list_count--;
        end
      end
      pal_pkg::REQ_FIND: begin
        for (i = 0; i < list_count && !hit; i++) begin
          if (list_words[i] == req.value) begin
            hit = 1'b1;
            resp.found_index = i[pal_pkg::FOUND_W-1:0];
          end
        end
        if (!hit) resp.status = pal_pkg::STAT_NOT_FOUND;
      end
      default: resp.status = pal_pkg::STAT_INVALID;
    endcase
    resp.entry_count = list_count[pal_pkg::COUNT_W-1:0];
    expected_resps.insert(expected_resps.size(), resp);
  endfunction

  // Queue a request and track the count it leaves, so positions can be aimed.
  function automatic void queue_request(logic [pal_pkg::REQ_W-1:0] kind, int unsigned pos,
                                        logic signed [pal_pkg::DATA_W-1:0] value);
    list_req_t req;
    req.kind  = kind;
    req.pos   = pos[pal_pkg::POS_W-1:0];
    req.value = value;
    pending_reqs.insert(pending_reqs.size(), req);
    case (kind)
      pal_pkg::REQ_APPEND: if (planned_count < LIST_DEPTH) planned_count++;
      pal_pkg::REQ_REMOVE: if (planned_count > 0) planned_count--;
      pal_pkg::REQ_INSERT:
        if (req.pos <= planned_count && planned_count < LIST_DEPTH) planned_count++;
      pal_pkg::REQ_ERASE:  if (req.pos < planned_count) planned_count--;
      default: ;
    endcase
  endfunction

  function automatic logic signed [pal_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 75) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic void queue_random_requests(int n);
    int sel;
    int unsigned pos;
    logic [pal_pkg::REQ_W-1:0] kind;
    for (int k = 0; k < n; k++) begin
      if (planned_count >= LIST_DEPTH) growing = 1'b0;
      else if (planned_count == 0) growing = 1'b1;
      else if ($urandom_range(0, 39) == 0) growing = !growing;
      if ($urandom_range(0, 99) < 8) begin
        // noise: any code, any position, any word
        queue_request(pal_pkg::REQ_W'($urandom_range(0, 7)), $urandom_range(0, 31), $urandom);
      end else begin
        sel = $urandom_range(0, 99);
        if (growing) begin
          kind = (sel < 30) ? pal_pkg::REQ_APPEND : (sel < 55) ? pal_pkg::REQ_INSERT :
                 (sel < 80) ? pal_pkg::REQ_FIND : (sel < 90) ? pal_pkg::REQ_REMOVE :
                 pal_pkg::REQ_ERASE;
        end else begin
          kind = (sel < 10) ? pal_pkg::REQ_APPEND : (sel < 20) ? pal_pkg::REQ_INSERT :
                 (sel < 45) ? pal_pkg::REQ_FIND : (sel < 70) ? pal_pkg::REQ_REMOVE :
                 pal_pkg::REQ_ERASE;
        end
        if (kind == pal_pkg::REQ_INSERT) pos = $urandom_range(0, planned_count);
        else if (kind == pal_pkg::REQ_ERASE && planned_count > 0)
          pos = $urandom_range(0, planned_count - 1);
        else pos = $urandom_range(0, 31);
        queue_request(kind, pos, pick_value());
      end
    end
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_resps.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int n, int idle_pct, int stall_pct);
    @(posedge clk_i);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random_requests(n);
    wait_drained();
  endtask

  // Request side: hold the payload until taken, then offer the next one or idle.
  always @(negedge clk_i) begin
    if (!in_valid_i || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i   <= 1'b1;
        req_type_i   <= pending_reqs[0].kind;
        position_i   <= pending_reqs[0].pos;
        item_value_i <= pending_reqs[0].value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    list_req_t req;
    req_taken = in_valid_i && in_ready_o;
    if (req_taken) begin
      req.kind  = req_type_i;
      req.pos   = position_i;
      req.value = item_value_i;
      apply_list_request(req);
      void'(pending_reqs.pop_front());
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= !hold_rx && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial forever begin
    @(hold_requests);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  always @(posedge clk_i) begin
    list_resp_t exp_resp;
    if (out_valid_o && out_ready_i) begin
      if (expected_resps.size() == 0) begin
        $error("unexpected result: status %0d found_index %0d entry_count %0d",
               status_o, found_index_o, entry_count_o);
        fail_count++;
      end else begin
        exp_resp = expected_resps.pop_front();
        if (status_o !== exp_resp.status) begin
          $error("status: expected %0d, got %0d", exp_resp.status, status_o);
          fail_count++;
        end
        if (found_index_o !== exp_resp.found_index) begin
          $error("found_index: expected %0d, got %0d", exp_resp.found_index, found_index_o);
          fail_count++;
        end
        if (entry_count_o !== exp_resp.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_resp.entry_count, entry_count_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = -32'sd1;
    value_pool[3] = 32'sd0;
    value_pool[4] = 32'sd1;
    for (int k = 5; k < POOL_SIZE; k++) value_pool[k] = $urandom;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // empty list corners, insert past the end, unused code
    queue_request(pal_pkg::REQ_REMOVE, 0, 32'sd0);
    queue_request(pal_pkg::REQ_ERASE, 0, 32'sd0);
    queue_request(pal_pkg::REQ_FIND, 0, -32'sd1);
    queue_request(pal_pkg::REQ_INSERT, 1, 32'sd5);
    queue_request(pal_pkg::REQ_INSERT, 0, 32'sh8000_0000);
    queue_request(pal_pkg::REQ_APPEND, 31, 32'sh7fff_ffff);
    queue_request(REQ_UNUSED, 0, 32'sd0);
    // fill to capacity, then push past it
    for (int k = 0; k < LIST_DEPTH - 2; k++) begin
      queue_request(pal_pkg::REQ_APPEND, 0, (k == 9) ? -32'sd1 : 32'(k * 3 + 7));
    end
    queue_request(pal_pkg::REQ_APPEND, 0, 32'sd99);
    queue_request(pal_pkg::REQ_INSERT, LIST_DEPTH, 32'sd99);
    queue_request(pal_pkg::REQ_INSERT, LIST_DEPTH + 1, 32'sd99);
    queue_request(pal_pkg::REQ_FIND, 0, -32'sd1);
    queue_request(pal_pkg::REQ_ERASE, LIST_DEPTH - 1, 32'sd0);
    queue_request(pal_pkg::REQ_ERASE, LIST_DEPTH - 1, 32'sd0);
    queue_request(pal_pkg::REQ_FIND, 0, 32'sd12345);
    wait_drained();

    run_phase(250, 0, 0);
    run_phase(250, 61, 0);
    run_phase(250, 0, 61);
    run_phase(250, 28, 28);

    // stall the result side while requests keep coming
    @(posedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    queue_random_requests(60);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_resps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
